FILE: design/dbi_icsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the DBI init command stream parser.
package dbi_icsp_pkg;

  localparam int unsigned MAX_FILE_BYTES_DEF = 65535;
  localparam int unsigned MIN_FILE_BYTES     = 18;
  localparam int unsigned MAGIC_LEN          = 15;
  localparam logic [7:0]  FORMAT_VERSION     = 8'd1;
  localparam logic [7:0]  SLEEP_OPCODE       = 8'h00;
  localparam logic [7:0]  SLEEP_PARAM_COUNT  = 8'd1;

  // Result queue geometry.
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_OPCODE = 2'd1,
    PH_COUNT  = 2'd2,
    PH_PARAMS = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_COMMAND = 2'd0,
    EV_PARAM   = 2'd1,
    EV_SLEEP   = 2'd2,
    EV_VERDICT = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    VD_OK        = 3'd0,
    VD_SMALL     = 3'd1,
    VD_MAGIC     = 3'd2,
    VD_VERSION   = 3'd3,
    VD_OVERFLOW  = 3'd4,
    VD_MALFORMED = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] event_value;
    logic [7:0] param_count;
    logic [2:0] verdict;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic valid;   // queue holds at least one result
    logic room;    // queue can take two more results
  } rq_status_t;

  // Expected header byte at a magic position: "MIPI DBI" then zeros.
  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h4D;
      4'd1:    b = 8'h49;
      4'd2:    b = 8'h50;
      4'd3:    b = 8'h49;
      4'd4:    b = 8'h20;
      4'd5:    b = 8'h44;
      4'd6:    b = 8'h42;
      4'd7:    b = 8'h49;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/dbi_icsp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the file byte input and the event output.
interface dbi_icsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface dbi_icsp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] event_value;
  logic [7:0] param_count;
  logic [2:0] verdict;
  logic       last_of_run;

  modport source (output valid, output event_kind, output event_value, output param_count,
                  output verdict, output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input event_value, input param_count,
                  input verdict, input last_of_run, output ready);
endinterface

FILE: design/dbi_icsp_parser.sv
`timescale 1ns / 1ps
// Framing state and per-byte event generation of the command stream parser.
module dbi_icsp_parser #(
  parameter int unsigned MAX_FILE_BYTES = dbi_icsp_pkg::MAX_FILE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            file_byte,
  input  logic                  end_of_file,
  output logic [1:0]            res_cnt,
  output dbi_icsp_pkg::result_t res0,
  output dbi_icsp_pkg::result_t res1
);

  localparam int unsigned PW = $clog2(MAX_FILE_BYTES + 1);

  dbi_icsp_pkg::phase_t   phase_r, phase_nxt;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic [7:0]             opcode_r, opcode_nxt;
  logic [7:0]             remain_r, remain_nxt, remain_dec;
  logic                   sleep_r, sleep_nxt;
  dbi_icsp_pkg::verdict_t err_r, err_nxt;

  dbi_icsp_pkg::result_t  ev, vd;
  logic                   ev_valid;

  // Next state after this byte, before the end-of-file return to reset.
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    remain_nxt = remain_r;
    sleep_nxt  = sleep_r;
    err_nxt    = err_r;
    remain_dec = (remain_r != 8'd0) ? remain_r - 8'd1 : remain_r;
    pos_nxt    = (pos_r < PW'(MAX_FILE_BYTES)) ? pos_r + 1'b1 : pos_r;
    case (phase_r)
      dbi_icsp_pkg::PH_HEADER: begin
        if (pos_r < PW'(dbi_icsp_pkg::MAGIC_LEN)) begin
          if (file_byte != dbi_icsp_pkg::magic_byte(pos_r[3:0]) &&
              err_r == dbi_icsp_pkg::VD_OK) begin
            err_nxt = dbi_icsp_pkg::VD_MAGIC;
          end
        end else begin
          if (file_byte != dbi_icsp_pkg::FORMAT_VERSION && err_r == dbi_icsp_pkg::VD_OK) begin
            err_nxt = dbi_icsp_pkg::VD_VERSION;
          end
          phase_nxt = dbi_icsp_pkg::PH_OPCODE;
        end
      end
      dbi_icsp_pkg::PH_OPCODE: begin
        opcode_nxt = file_byte;
        phase_nxt  = dbi_icsp_pkg::PH_COUNT;
      end
      dbi_icsp_pkg::PH_COUNT: begin
        if (opcode_r == dbi_icsp_pkg::SLEEP_OPCODE &&
            file_byte == dbi_icsp_pkg::SLEEP_PARAM_COUNT) begin
          sleep_nxt  = 1'b1;
          remain_nxt = dbi_icsp_pkg::SLEEP_PARAM_COUNT;
          phase_nxt  = dbi_icsp_pkg::PH_PARAMS;
        end else begin
          remain_nxt = file_byte;
          phase_nxt  = (file_byte != 8'd0) ? dbi_icsp_pkg::PH_PARAMS
                                           : dbi_icsp_pkg::PH_OPCODE;
        end
      end
      dbi_icsp_pkg::PH_PARAMS: begin
        sleep_nxt  = 1'b0;
        remain_nxt = remain_dec;
        if (remain_dec == 8'd0) begin
          phase_nxt = dbi_icsp_pkg::PH_OPCODE;
        end
      end
      default: phase_nxt = dbi_icsp_pkg::PH_HEADER;
    endcase
  end

  // Results caused by this byte.
  always_comb begin
    ev_valid       = 1'b0;
    ev             = '0;
    ev.last_of_run = ~end_of_file;
    case (phase_r)
      dbi_icsp_pkg::PH_COUNT: begin
        if (!(opcode_r == dbi_icsp_pkg::SLEEP_OPCODE &&
              file_byte == dbi_icsp_pkg::SLEEP_PARAM_COUNT)) begin
          ev_valid       = 1'b1;
          ev.event_kind  = dbi_icsp_pkg::EV_COMMAND;
          ev.event_value = opcode_r;
          ev.param_count = file_byte;
        end
      end
      dbi_icsp_pkg::PH_PARAMS: begin
        ev_valid       = 1'b1;
        ev.event_kind  = sleep_r ? dbi_icsp_pkg::EV_SLEEP : dbi_icsp_pkg::EV_PARAM;
        ev.event_value = file_byte;
      end
      default: ev_valid = 1'b0;
    endcase

    vd             = '0;
    vd.event_kind  = dbi_icsp_pkg::EV_VERDICT;
    vd.last_of_run = 1'b1;
    if (pos_nxt < PW'(dbi_icsp_pkg::MIN_FILE_BYTES)) begin
      vd.verdict = dbi_icsp_pkg::VD_SMALL;
    end else if (err_nxt != dbi_icsp_pkg::VD_OK) begin
      vd.verdict = err_nxt;
    end else if (phase_nxt == dbi_icsp_pkg::PH_COUNT) begin
      vd.verdict = dbi_icsp_pkg::VD_MALFORMED;
    end else if (phase_nxt == dbi_icsp_pkg::PH_PARAMS) begin
      vd.verdict = dbi_icsp_pkg::VD_OVERFLOW;
    end else begin
      vd.verdict = dbi_icsp_pkg::VD_OK;
    end

    res0    = ev_valid ? ev : vd;
    res1    = vd;
    res_cnt = {1'b0, ev_valid} + {1'b0, end_of_file};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && end_of_file)) begin
      phase_r  <= dbi_icsp_pkg::PH_HEADER;
      pos_r    <= '0;
      opcode_r <= '0;
      remain_r <= '0;
      sleep_r  <= 1'b0;
      err_r    <= dbi_icsp_pkg::VD_OK;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      opcode_r <= opcode_nxt;
      remain_r <= remain_nxt;
      sleep_r  <= sleep_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

FILE: design/dbi_icsp_rq.sv
`timescale 1ns / 1ps
// Small result queue that takes up to two results per cycle and gives one.
module dbi_icsp_rq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 push_cnt,
  input  dbi_icsp_pkg::result_t      wdata0,
  input  dbi_icsp_pkg::result_t      wdata1,
  input  logic                       pop,
  output dbi_icsp_pkg::result_t      rdata,
  output dbi_icsp_pkg::rq_status_t   status
);

  localparam int unsigned AW = dbi_icsp_pkg::RQ_AW;
  localparam int unsigned CW = dbi_icsp_pkg::RQ_CW;

  dbi_icsp_pkg::result_t mem_r [dbi_icsp_pkg::RQ_DEPTH];
  logic [AW-1:0]         wr_ptr_r, rd_ptr_r, wr_ptr1;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  do_pop;

  assign do_pop        = pop && (cnt_r != '0);
  assign wr_ptr1       = wr_ptr_r + 1'b1;
  assign cnt_nxt       = cnt_r + CW'(push_cnt) - CW'(do_pop);
  assign rdata         = mem_r[rd_ptr_r];
  assign status.valid  = (cnt_r != '0);
  assign status.room   = (cnt_r <= CW'(dbi_icsp_pkg::RQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= wdata0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr1] <= wdata1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(push_cnt);
      rd_ptr_r <= rd_ptr_r + AW'(do_pop);
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: design/dbi_init_command_stream_parser.sv
`timescale 1ns / 1ps
// Top level of the DBI panel init file checker and command framer.
//
// The block takes one file byte per cycle and keeps taking bytes at that rate
// for as long as the event side keeps up. Each byte is parsed in the cycle it
// is accepted: header bytes are checked against the magic and the version,
// body bytes are framed into command, parameter and sleep events, and the byte
// marked end of file adds a verdict after any event it caused. The zero, one
// or two results of a byte are written into a four-entry result queue, so the
// first of them is registered in the queue before it is offered on the output.
// in_ch.ready is high whenever the queue has room for two more results; a byte
// that carries end of file together with an event therefore puts two results
// in the queue, and a stalled output fills it before the input is held off.
// After the verdict the parser is back in its reset state and the next byte
// starts a new file. Events of a file whose verdict is not ok are still
// delivered and should be dropped downstream.
module dbi_init_command_stream_parser #(
  parameter int unsigned MAX_FILE_BYTES = dbi_icsp_pkg::MAX_FILE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dbi_icsp_in_if.sink           in_ch,
  dbi_icsp_out_if.source        out_ch
);

  dbi_icsp_pkg::result_t    res0, res1, head;
  dbi_icsp_pkg::rq_status_t rq_status;
  logic [1:0]               res_cnt, push_cnt;
  logic                     in_fire;

  // Accept only while the queue can absorb the worst case of two results.
  assign in_ch.ready = rq_status.room;
  assign in_fire     = in_ch.valid && rq_status.room;
  assign push_cnt    = in_fire ? res_cnt : 2'd0;

  dbi_icsp_parser #(
    .MAX_FILE_BYTES(MAX_FILE_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .file_byte   (in_ch.file_byte),
    .end_of_file (in_ch.end_of_file),
    .res_cnt     (res_cnt),
    .res0        (res0),
    .res1        (res1)
  );

  dbi_icsp_rq u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .wdata0   (res0),
    .wdata1   (res1),
    .pop      (out_ch.ready),
    .rdata    (head),
    .status   (rq_status)
  );

  // The queue head drives the event channel directly.
  assign out_ch.valid       = rq_status.valid;
  assign out_ch.event_kind  = head.event_kind;
  assign out_ch.event_value = head.event_value;
  assign out_ch.param_count = head.param_count;
  assign out_ch.verdict     = head.verdict;
  assign out_ch.last_of_run = head.last_of_run;

endmodule

FILE: design/dbi_icsp_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the command stream parser and their bind.
module dbi_icsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_end_of_file,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_kind,
  input logic [2:0] out_verdict,
  input logic       out_last_of_run
);

  // A pending event is not withdrawn before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output event withdrawn while stalled");

  // The last byte of a file always produces a verdict, so output must follow.
  a_eof_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_file |=> out_valid)
    else $error("no result after end of file");

  // A verdict always closes the run of results of its byte.
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == dbi_icsp_pkg::EV_VERDICT |-> out_last_of_run)
    else $error("verdict not marked last of run");

  // Non-verdict events carry a zero verdict; verdict codes stay in range.
  a_verdict_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != dbi_icsp_pkg::EV_VERDICT |-> out_verdict == 3'd0)
    else $error("verdict field set on a non-verdict event");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict <= dbi_icsp_pkg::VD_MALFORMED)
    else $error("verdict code out of range");

endmodule

bind dbi_init_command_stream_parser dbi_icsp_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_end_of_file  (in_ch.end_of_file),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_event_kind  (out_ch.event_kind),
  .out_verdict     (out_ch.verdict),
  .out_last_of_run (out_ch.last_of_run)
);
